// ----- src/mla_pkg.sv -----
// ----------------------------------------------------------------------------
// mla_pkg
// Shared types, constants and helpers of the multilook amplitude-to-byte block.
// ----------------------------------------------------------------------------
package mla_pkg;

  localparam int DEF_MAX_LOOK_LINES = 16;
  localparam int DEF_MAX_GROUPS     = 1024;
  localparam int DEF_MAX_WIDTH      = 4096;
  localparam int DEF_SAMPLE_BITS    = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int AREA_W     = 10;
  localparam int FRAC_BITS  = 16;
  localparam int GAIN_W     = 16;
  localparam int PIXEL_W    = 8;
  localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'd255;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LOOK_LINES   = 3'd0,
    CFG_LOOK_SAMPLES = 3'd1,
    CFG_STEP_LINES   = 3'd2,
    CFG_STEP_SAMPLES = 3'd3,
    CFG_LINE_WIDTH   = 3'd4,
    CFG_GAIN         = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [4:0]        look_lines;
    logic [4:0]        look_samples;
    logic [4:0]        step_lines;
    logic [4:0]        step_samples;
    logic [12:0]       line_width;
    logic [GAIN_W-1:0] gain;
  } cfg_regs_t;

  function automatic logic [4:0] at_least_one(input logic [4:0] v);
    return (v == 5'd0) ? 5'd1 : v;
  endfunction

  function automatic logic [4:0] eff_ll(input logic [4:0] v, input int max_ll);
    logic [4:0] r;
    r = at_least_one(v);
    if (32'(r) > max_ll) r = 5'(max_ll);
    return r;
  endfunction

  function automatic logic [12:0] eff_width(input logic [12:0] v, input int max_w);
    logic [12:0] r;
    r = (v == 13'd0) ? 13'd1 : v;
    if (32'(r) > max_w) r = 13'(max_w);
    return r;
  endfunction

endpackage

// ----- src/mla_front.sv -----
// ----------------------------------------------------------------------------
// mla_front
// Sample intake: squares, accumulates groups, tracks rows and stores row sums.
// ----------------------------------------------------------------------------
module mla_front #(
  parameter int MAX_LOOK_LINES = 16,
  parameter int MAX_GROUPS     = 1024,
  parameter int MAX_WIDTH      = 4096,
  parameter int SAMPLE_BITS    = 16,
  parameter int ACC_W          = 43,
  parameter int CW             = 12,
  parameter int SLOT_W         = 4,
  parameter int ADDR_W         = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mla_pkg::cfg_regs_t            cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_first,
  input  logic                          store_free,
  output logic                          job_valid,
  output logic [ACC_W-1:0]              job_acc,
  output logic [CW-1:0]                 job_gi,
  output logic [SLOT_W-1:0]             job_slot,
  output logic                          job_stored,
  output logic                          job_last,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic [ACC_W-1:0]              rd_data
);
  import mla_pkg::*;

  logic [ACC_W-1:0] mem [MAX_LOOK_LINES*MAX_GROUPS];

  logic [ACC_W-1:0]  acc_r;
  logic [CW-1:0]     col_r, gi_r;
  logic [SLOT_W-1:0] slot_r;
  logic [4:0]        rue_r;

  logic [ACC_W-1:0]       acc_e, acc_new;
  logic [CW-1:0]          col_e, gi_e;
  logic [SLOT_W-1:0]      slot_e;
  logic [4:0]             rue_e, ll, ss;
  logic [12:0]            w;
  logic [SAMPLE_BITS-1:0] mag;
  logic [2*SAMPLE_BITS-1:0] sq;
  logic [CW+6:0]          gend;
  logic                   end_row, end_group, stored, accept;
  logic [ADDR_W-1:0]      wr_addr;

  always_comb begin
    ll     = eff_ll(cfg.look_lines, MAX_LOOK_LINES);
    ss     = at_least_one(cfg.step_samples);
    w      = eff_width(cfg.line_width, MAX_WIDTH);
    acc_e  = in_first ? '0 : acc_r;
    col_e  = in_first ? '0 : col_r;
    gi_e   = in_first ? '0 : gi_r;
    slot_e = in_first ? '0 : slot_r;
    rue_e  = in_first ? ll - 5'd1 : rue_r;
    mag    = in_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_sample) : SAMPLE_BITS'(in_sample);
    sq     = mag * mag;
    acc_new = acc_e + ACC_W'(sq);
    end_row = 32'(col_e) >= 32'(w) - 1;
    gend    = (CW+7)'(gi_e) * (CW+7)'(ss) + (CW+7)'(ss) - (CW+7)'(1);
    end_group = end_row || ((CW+7)'(col_e) >= gend);
    stored  = 32'(gi_e) < MAX_GROUPS;
    wr_addr = ADDR_W'(slot_e) * ADDR_W'(MAX_GROUPS) + ADDR_W'(gi_e);
  end

  assign in_ready   = !end_group || store_free;
  assign accept     = in_valid && in_ready;
  assign job_valid  = accept && end_group && (rue_e == 5'd0);
  assign job_acc    = acc_new;
  assign job_gi     = gi_e;
  assign job_slot   = slot_e;
  assign job_stored = stored;
  assign job_last   = end_row;

  always_ff @(posedge clk) begin
    if (accept && end_group && stored) begin
      mem[wr_addr] <= acc_new;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      col_r  <= '0;
      gi_r   <= '0;
      slot_r <= '0;
      rue_r  <= '0;
    end else if (accept) begin
      acc_r <= end_group ? '0 : acc_new;
      if (end_row) begin
        col_r  <= '0;
        gi_r   <= '0;
        slot_r <= (32'(slot_e) == MAX_LOOK_LINES - 1) ? '0 : slot_e + SLOT_W'(1);
        rue_r  <= (rue_e == 5'd0) ? at_least_one(cfg.step_lines) - 5'd1 : rue_e - 5'd1;
      end else begin
        col_r  <= col_e + CW'(1);
        gi_r   <= end_group ? gi_e + CW'(1) : gi_e;
        slot_r <= slot_e;
        rue_r  <= rue_e;
      end
    end
  end

endmodule

// ----- src/mla_queue.sv -----
// ----------------------------------------------------------------------------
// mla_queue
// Two-entry queue of group requests between intake and pixel computation.
// ----------------------------------------------------------------------------
module mla_queue #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  import mla_pkg::*;

  logic [W-1:0] ent_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign dout  = ent_r[rp_r];
  assign empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- src/mla_back.sv -----
// ----------------------------------------------------------------------------
// mla_back
// Pixel engine: window sum over stored rows, divide, square root, gain, clip.
// ----------------------------------------------------------------------------
module mla_back #(
  parameter int MAX_LOOK_LINES = 16,
  parameter int MAX_GROUPS     = 1024,
  parameter int ACC_W          = 43,
  parameter int CW             = 12,
  parameter int SLOT_W         = 4,
  parameter int ADDR_W         = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mla_pkg::cfg_regs_t cfg,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic [ACC_W-1:0]   job_acc,
  input  logic [CW-1:0]      job_gi,
  input  logic [SLOT_W-1:0]  job_slot,
  input  logic               job_stored,
  input  logic               job_last,
  output logic               rd_busy,
  output logic [ADDR_W-1:0]  rd_addr,
  input  logic [ACC_W-1:0]   rd_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [mla_pkg::PIXEL_W-1:0] out_pixel,
  output logic               out_last
);
  import mla_pkg::*;

  localparam int SUM_W = ACC_W + 5;
  localparam int DIV_W = SUM_W + FRAC_BITS;
  localparam int SQ_W  = (DIV_W > 63) ? 64 : DIV_W + (DIV_W % 2);
  localparam int RT_W  = SQ_W / 2;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam int PR_W  = RT_W + GAIN_W;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_DIV, S_SQRT, S_MUL, S_RND, S_FIN} st_t;

  st_t               st_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CW-1:0]     gi_r;
  logic [SLOT_W-1:0] slot_r;
  logic              stored_r, last_r, pend_r;
  logic [4:0]        k_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_W-1:0]  dq_r;
  logic [AREA_W-1:0] rem_r;
  logic [SQ_W-1:0]   rad_r;
  logic [RT_W+1:0]   srem_r;
  logic [RT_W-1:0]   root_r;
  logic [PR_W-1:0]   prod_r;
  logic [PIXEL_W-1:0] pix_r;
  logic              ov_r;
  logic [PIXEL_W-1:0] opix_r;
  logic              olast_r;

  logic [4:0]        ll;
  logic [AREA_W-1:0] area;
  logic              issue;
  logic [7:0]        rslot;
  logic [AREA_W:0]   dt;
  logic              dge;
  logic [SQ_W-1:0]   q_clamp;
  logic [RT_W+1:0]   s_sh, s_tr;
  logic              sge;
  logic [PR_W:0]     rnd;

  generate
    if (DIV_W > 63) begin : g_sat
      assign q_clamp = (|dq_r[DIV_W-1:63]) ? {1'b1, 63'd0} : dq_r[63:0];
    end else begin : g_nosat
      assign q_clamp = SQ_W'(dq_r);
    end
  endgenerate

  always_comb begin
    ll    = eff_ll(cfg.look_lines, MAX_LOOK_LINES);
    area  = AREA_W'(ll) * AREA_W'(at_least_one(cfg.look_samples));
    issue = (st_r == S_RD) && stored_r && (k_r < ll);
    rslot = 8'(slot_r) + 8'(MAX_LOOK_LINES) - 8'(k_r);
    if (32'(rslot) >= MAX_LOOK_LINES) rslot = rslot - 8'(MAX_LOOK_LINES);
    rd_addr = ADDR_W'(rslot) * ADDR_W'(MAX_GROUPS) + ADDR_W'(gi_r);
    dt    = {rem_r, dq_r[DIV_W-1]};
    dge   = dt >= {1'b0, area};
    s_sh  = {srem_r[RT_W-1:0], rad_r[SQ_W-1:SQ_W-2]};
    s_tr  = {root_r, 2'b01};
    sge   = s_sh >= s_tr;
    rnd   = (PR_W+1)'(prod_r) + (PR_W+1)'(32768);
  end

  assign q_pop     = (st_r == S_IDLE) && !q_empty;
  assign rd_busy   = (st_r == S_RD);
  assign out_valid = ov_r;
  assign out_pixel = opix_r;
  assign out_last  = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (ov_r && out_ready && (st_r != S_FIN)) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            sum_r    <= SUM_W'(job_acc);
            gi_r     <= job_gi;
            slot_r   <= job_slot;
            stored_r <= job_stored;
            last_r   <= job_last;
            k_r      <= 5'd1;
            pend_r   <= 1'b0;
            st_r     <= S_RD;
          end
        end
        S_RD: begin
          if (pend_r) sum_r <= sum_r + SUM_W'(rd_data);
          pend_r <= issue;
          if (issue) k_r <= k_r + 5'd1;
          if (!issue && !pend_r) begin
            dq_r  <= {sum_r, FRAC_BITS'(0)};
            rem_r <= '0;
            cnt_r <= CNT_W'(DIV_W);
            st_r  <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt_r == '0) begin
            rad_r  <= q_clamp;
            srem_r <= '0;
            root_r <= '0;
            cnt_r  <= CNT_W'(RT_W);
            st_r   <= S_SQRT;
          end else begin
            rem_r <= dge ? AREA_W'(dt - {1'b0, area}) : AREA_W'(dt);
            dq_r  <= {dq_r[DIV_W-2:0], dge};
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        S_SQRT: begin
          if (cnt_r == '0) begin
            st_r <= S_MUL;
          end else begin
            srem_r <= sge ? s_sh - s_tr : s_sh;
            root_r <= {root_r[RT_W-2:0], sge};
            rad_r  <= {rad_r[SQ_W-3:0], 2'b00};
            cnt_r  <= cnt_r - CNT_W'(1);
          end
        end
        S_MUL: begin
          prod_r <= PR_W'(root_r) * PR_W'(cfg.gain);
          st_r   <= S_RND;
        end
        S_RND: begin
          pix_r <= (|rnd[PR_W:FRAC_BITS+PIXEL_W]) ? PIXEL_MAX
                                                  : rnd[FRAC_BITS+PIXEL_W-1:FRAC_BITS];
          st_r  <= S_FIN;
        end
        S_FIN: begin
          if (!ov_r || out_ready) begin
            ov_r    <= 1'b1;
            opix_r  <= pix_r;
            olast_r <= last_r;
            st_r    <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/multilook_amplitude_to_byte.sv -----
// ----------------------------------------------------------------------------
// multilook_amplitude_to_byte
// Multilook amplitude averaging of a raster sample stream into output bytes.
// ----------------------------------------------------------------------------
// Intake takes one sample per cycle; a sample that closes a group waits until
// the pixel engine has taken the previous request and finished reading its rows.
// The pixel engine works on one request at a time: serial read of the row store,
// one quotient bit and one root bit per cycle, gain multiply, rounding and clip,
// then it holds the pixel while the output stalls. Synchronous active-low reset
// clears tracking and loads register defaults; the row store is not cleared.
// ----------------------------------------------------------------------------
module multilook_amplitude_to_byte #(
  parameter int MAX_LOOK_LINES = mla_pkg::DEF_MAX_LOOK_LINES,
  parameter int MAX_GROUPS     = mla_pkg::DEF_MAX_GROUPS,
  parameter int MAX_WIDTH      = mla_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS    = mla_pkg::DEF_SAMPLE_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,   // sample
  input  logic                             in_tuser,   // first_of_image
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // pixel
  output logic                             out_tlast,
  input  logic                             cfg_wr_en,
  input  logic [mla_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [mla_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mla_pkg::*;

  localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SLOT_W = (MAX_LOOK_LINES > 1) ? $clog2(MAX_LOOK_LINES) : 1;
  localparam int ADDR_W = (MAX_LOOK_LINES*MAX_GROUPS > 1) ?
                          $clog2(MAX_LOOK_LINES*MAX_GROUPS) : 1;
  localparam int ACC_W  = 2*SAMPLE_BITS - 1 + $clog2(MAX_WIDTH);
  localparam int JOB_W  = ACC_W + CW + SLOT_W + 2;

  cfg_regs_t cfg_r;

  logic              store_free, job_valid, job_stored, job_last;
  logic [ACC_W-1:0]  job_acc, rd_data;
  logic [CW-1:0]     job_gi;
  logic [SLOT_W-1:0] job_slot;
  logic [ADDR_W-1:0] rd_addr;
  logic              q_empty, q_pop, rd_busy;
  logic [JOB_W-1:0]  q_dout;
  logic [ACC_W-1:0]  b_acc;
  logic [CW-1:0]     b_gi;
  logic [SLOT_W-1:0] b_slot;
  logic              b_stored, b_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.look_lines   <= 5'd1;
      cfg_r.look_samples <= 5'd1;
      cfg_r.step_lines   <= 5'd1;
      cfg_r.step_samples <= 5'd1;
      cfg_r.line_width   <= 13'd1024;
      cfg_r.gain         <= 16'd256;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_LOOK_LINES:   cfg_r.look_lines   <= cfg_wdata[4:0];
        CFG_LOOK_SAMPLES: cfg_r.look_samples <= cfg_wdata[4:0];
        CFG_STEP_LINES:   cfg_r.step_lines   <= cfg_wdata[4:0];
        CFG_STEP_SAMPLES: cfg_r.step_samples <= cfg_wdata[4:0];
        CFG_LINE_WIDTH:   cfg_r.line_width   <= cfg_wdata[12:0];
        CFG_GAIN:         cfg_r.gain         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign store_free = q_empty && !rd_busy;

  mla_front #(
    .MAX_LOOK_LINES(MAX_LOOK_LINES), .MAX_GROUPS(MAX_GROUPS), .MAX_WIDTH(MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS), .ACC_W(ACC_W), .CW(CW), .SLOT_W(SLOT_W), .ADDR_W(ADDR_W)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_sample(in_tdata[SAMPLE_BITS-1:0]), .in_first(in_tuser),
    .store_free(store_free),
    .job_valid(job_valid), .job_acc(job_acc), .job_gi(job_gi), .job_slot(job_slot),
    .job_stored(job_stored), .job_last(job_last),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  mla_queue #(.W(JOB_W)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(job_valid), .din({job_acc, job_gi, job_slot, job_stored, job_last}),
    .pop(q_pop), .dout(q_dout), .empty(q_empty)
  );

  assign {b_acc, b_gi, b_slot, b_stored, b_last} = q_dout;

  mla_back #(
    .MAX_LOOK_LINES(MAX_LOOK_LINES), .MAX_GROUPS(MAX_GROUPS), .ACC_W(ACC_W),
    .CW(CW), .SLOT_W(SLOT_W), .ADDR_W(ADDR_W)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_empty(q_empty), .q_pop(q_pop),
    .job_acc(b_acc), .job_gi(b_gi), .job_slot(b_slot),
    .job_stored(b_stored), .job_last(b_last),
    .rd_busy(rd_busy), .rd_addr(rd_addr), .rd_data(rd_data),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_pixel(out_tdata), .out_last(out_tlast)
  );

endmodule

// ----- bench/multilook_pixel_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilook_pixel_checker
// Watches the sample, pixel and register channels of the multilook block,
// predicts every output byte from its own copy of the row store and tracking
// state, and compares each accepted pixel with the oldest prediction.
// ----------------------------------------------------------------------------
module multilook_pixel_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // sample
  input  logic                           in_tuser,   // first_of_image
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [7:0]                     out_tdata,  // pixel
  input  logic                           out_tlast,
  input  logic                           cfg_wr_en,
  input  logic [mla_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mla_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             errors,
  output int                             pending
);
  import mla_pkg::*;

  localparam int ROWS   = 16;
  localparam int GROUPS = 1024;

  typedef struct {
    logic [7:0] pixel;
    logic       last_in_line;
  } pixel_t;

  pixel_t      expected_pixels[$];
  logic [63:0] row_sums[ROWS*GROUPS];
  logic [63:0] group_acc;
  int unsigned column, group_idx, slot, rows_left;
  logic [4:0]  look_lines, look_samples, step_lines, step_samples;
  logic [12:0] line_width;
  logic [15:0] gain;

  function automatic int unsigned lines_eff();
    if (look_lines == 0) return 1;
    if (look_lines > ROWS) return ROWS;
    return look_lines;
  endfunction

  function automatic int unsigned one_min(logic [4:0] v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int unsigned width_eff();
    if (line_width == 0) return 1;
    if (line_width > 4096) return 4096;
    return line_width;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [7:0] scale_pixel(logic [63:0] sum);
    logic [63:0] area, hi, q, r, p;
    area = lines_eff() * one_min(look_samples);
    hi = sum / area;
    if (hi >= (64'd1 << 47)) q = 64'd1 << 63;
    else q = (hi << 16) + (((sum % area) << 16) / area);
    r = int_sqrt(q);
    p = (r * gain + 64'd32768) >> 16;
    return (p > 255) ? 8'd255 : p[7:0];
  endfunction

  task automatic restart_image();
    group_acc = 0;
    column = 0;
    group_idx = 0;
    slot = 0;
    rows_left = lines_eff() - 1;
  endtask

  task automatic predict_sample(logic [15:0] raw, logic first);
    logic [63:0] mag, sum;
    int unsigned ll, ss, w;
    logic        row_end, grp_end, stored;
    pixel_t      px;
    ll = lines_eff();
    ss = one_min(step_samples);
    w = width_eff();
    if (first) restart_image();
    mag = raw[15] ? (64'd65536 - raw) : raw;
    group_acc += mag * mag;
    row_end = column >= w - 1;
    grp_end = row_end || (64'(column) >= 64'(group_idx) * ss + ss - 1);
    if (grp_end) begin
      stored = group_idx < GROUPS;
      if (stored) row_sums[slot*GROUPS + group_idx] = group_acc;
      if (rows_left == 0) begin
        sum = group_acc;
        if (stored)
          for (int k = 1; k < ll; k++)
            sum += row_sums[((slot + ROWS - k) % ROWS)*GROUPS + group_idx];
        px.pixel = scale_pixel(sum);
        px.last_in_line = row_end;
        expected_pixels.push_back(px);
      end
      group_acc = 0;
      group_idx++;
    end
    if (row_end) begin
      column = 0;
      group_idx = 0;
      slot = (slot + 1) % ROWS;
      if (rows_left == 0) rows_left = one_min(step_lines) - 1;
      else rows_left--;
    end else begin
      column++;
    end
  endtask

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("%0t: %s got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    pixel_t px;
    if (!rst_n) begin
      errors = 0;
      look_lines = 1;
      look_samples = 1;
      step_lines = 1;
      step_samples = 1;
      line_width = 1024;
      gain = 256;
      restart_image();
      expected_pixels.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_LOOK_LINES:   look_lines = cfg_wdata[4:0];
          CFG_LOOK_SAMPLES: look_samples = cfg_wdata[4:0];
          CFG_STEP_LINES:   step_lines = cfg_wdata[4:0];
          CFG_STEP_SAMPLES: step_samples = cfg_wdata[4:0];
          CFG_LINE_WIDTH:   line_width = cfg_wdata[12:0];
          CFG_GAIN:         gain = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_sample(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          report("unexpected pixel", out_tdata, 0);
        end else begin
          px = expected_pixels.pop_front();
          if (out_tdata !== px.pixel) report("pixel", out_tdata, px.pixel);
          if (out_tlast !== px.last_in_line)
            report("last_in_line", out_tlast, px.last_in_line);
        end
      end
    end
    pending <= expected_pixels.size();
  end

endmodule

// ----- bench/multilook_amplitude_to_byte_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilook_amplitude_to_byte_test
// Drives images of amplitude samples through the multilook block under a
// series of register settings, directed extremes first and random images
// after, with random idling on both channels; the checker does the compare.
// ----------------------------------------------------------------------------
module multilook_amplitude_to_byte_test;
  import mla_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 5000000;
  localparam int SETTLE       = 300;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;   // sample
  logic                  in_tuser = 1'b0; // first_of_image
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;       // pixel
  logic                  out_tlast;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    errors, pending;
  int                    cycles = 0;
  int                    sent = 0;
  bit                    no_idle = 1'b0;
  bit                    long_hold = 1'b0;

  multilook_amplitude_to_byte i_dut (.*);

  multilook_pixel_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("multilook_amplitude_to_byte: mismatch");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, int unsigned value);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic configure(int unsigned ll, ls, sl, ss, w, g);
    write_reg(CFG_LOOK_LINES, ll);
    write_reg(CFG_LOOK_SAMPLES, ls);
    write_reg(CFG_STEP_LINES, sl);
    write_reg(CFG_STEP_SAMPLES, ss);
    write_reg(CFG_LINE_WIDTH, w);
    write_reg(CFG_GAIN, g);
  endtask

  task automatic send_sample(logic [15:0] value, logic first);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= value;
    in_tuser <= first;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_image(int unsigned count);
    for (int i = 0; i < count; i++)
      send_sample(pick_sample(), i == 0 || $urandom_range(0, 199) == 0);
  endtask

  always @(posedge clk) begin
    int gap;
    if (rst_n) begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    int unsigned ll, sl, ss, w, rows;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(1, 1, 1, 1, 4, 256);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h5555, 1'b1);
    send_sample(16'hAAAA, 1'b0);
    drain();
    configure(1, 1, 1, 2, 3, 65535);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 16'h8000 : 16'h7FFF, i == 0);
    drain();
    configure(0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 4; i++) send_sample(pick_sample(), i == 0);
    drain();
    configure(31, 31, 31, 31, 3, 65535);
    for (int i = 0; i < 51; i++) send_sample(16'h8000, i == 0);
    drain();
    configure(1, 16, 1, 16, 8191, 1000);
    no_idle = 1'b1;
    send_image(64);
    drain();
    configure(2, 3, 1, 2, 20, 700);
    send_image(60);
    no_idle = 1'b0;
    drain();
    configure(1, 1, 1, 1, 16, $urandom_range(0, 65535));
    long_hold = 1'b1;
    send_image(96);
    drain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      ll = $urandom_range(1, 16);
      sl = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(1, ll);
      ss = $urandom_range(1, 16);
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
      rows = ll + $urandom_range(0, 4);
      if (ll > 6) w = $urandom_range(1, 8);
      no_idle = $urandom_range(0, 3) == 0;
      configure(ll, $urandom_range(0, 16), sl, ss, w, $urandom_range(0, 65535));
      send_image(rows * w);
      drain();
    end

    if (errors == 0)
      $display("multilook_amplitude_to_byte: match");
    else
      $display("multilook_amplitude_to_byte: mismatch");
    $finish;
  end

endmodule
